// File: hw/rtl/tkpq_pkg.sv
// ----------------------------------------------------------------------------
// Two-key priority queue package
// Shared record type, codes and the priority compare used by the cell row.
// ----------------------------------------------------------------------------
package tkpq_pkg;

  localparam int unsigned QueueDepth = 64;
  localparam int unsigned CountW     = $clog2(QueueDepth + 1);
  localparam int unsigned IdW        = 16;
  localparam int unsigned TimeW      = 32;
  localparam int unsigned CntrW      = 8;
  localparam int unsigned RecW       = IdW + TimeW + CntrW;
  localparam int unsigned InDataW    = ((RecW + 7) / 8) * 8;
  localparam int unsigned OutDataW   = ((RecW + CountW + 7) / 8) * 8;
  localparam int unsigned StatusW    = 2;

  localparam logic FuncEnq = 1'b0;
  localparam logic FuncDeq = 1'b1;

  localparam logic [StatusW-1:0] StDone  = 2'd0;
  localparam logic [StatusW-1:0] StEmpty = 2'd1;
  localparam logic [StatusW-1:0] StFull  = 2'd2;

  // Packed so that the identifier sits in the lowest bits.
  typedef struct packed {
    logic [CntrW-1:0] counter;
    logic [TimeW-1:0] tkey;
    logic [IdW-1:0]   id;
  } rec_t;

  typedef struct packed {
    logic ins;
    logic deq;
  } cell_ctrl_t;

  // True when record a must leave strictly before record b.
  function automatic logic rec_beats(rec_t a, rec_t b);
    logic res;
    if (a.tkey != b.tkey) begin
      res = (a.tkey < b.tkey);
    end else begin
      res = (a.counter > b.counter);
    end
    return res;
  endfunction

endpackage

// File: hw/rtl/tkpq_cell.sv
// ----------------------------------------------------------------------------
// Priority queue cell
// Holds one record of the sorted row; shifts right on insert, left on removal.
// ----------------------------------------------------------------------------
module tkpq_cell (
  input  logic                clk_i,
  input  tkpq_pkg::cell_ctrl_t ctrl_i,
  input  logic                valid_i,     // this cell holds a live record
  input  tkpq_pkg::rec_t      new_rec_i,
  input  tkpq_pkg::rec_t      left_rec_i,
  input  logic                left_goes_i, // new record lands at or left of the left cell
  input  tkpq_pkg::rec_t      right_rec_i,
  output tkpq_pkg::rec_t      rec_o,
  output logic                goes_o       // new record lands at or left of this cell
);
  import tkpq_pkg::*;

  rec_t rec_q, rec_d;

  // An empty cell always takes the new record's side; the row stays sorted,
  // so the compare is monotonic along the chain.
  assign goes_o = !valid_i || rec_beats(new_rec_i, rec_q);

  always_comb begin
    rec_d = rec_q;
    priority if (ctrl_i.deq) begin
      rec_d = right_rec_i;
    end else if (ctrl_i.ins && left_goes_i) begin
      rec_d = left_rec_i;
    end else if (ctrl_i.ins && goes_o) begin
      rec_d = new_rec_i;
    end else begin
      rec_d = rec_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign rec_o = rec_q;

endmodule

// File: hw/rtl/two_key_priority_queue.sv
// ----------------------------------------------------------------------------
// Two-key priority queue
// Sorted row of cells, head at cell zero; one result beat per input beat.
// ----------------------------------------------------------------------------
// Each result beat is registered and presented in the cycle after its input beat.
// One beat per cycle unless the result stream stalls; every cell compares against the
// incoming record in parallel and moves by one place, so no item waits on another.
// Reset: clears the record count and the output valid; cell contents are
// left as they are and are only read below the count.
module two_key_priority_queue (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [tkpq_pkg::InDataW-1:0]    s_axis_tdata_i,  // rec_id, rec_time, rec_counter
  input  logic                            s_axis_tuser_i,  // func
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [tkpq_pkg::OutDataW-1:0]   m_axis_tdata_o,  // out_id, out_time, out_counter,
                                                           // occupancy, zero pad
  output logic [tkpq_pkg::StatusW-1:0]    m_axis_tuser_o   // status
);
  import tkpq_pkg::*;

  logic [CountW-1:0]  count_q, count_d;
  logic               out_valid_q, out_valid_d;
  rec_t               out_rec_q, out_rec_d;
  logic [StatusW-1:0] out_status_q, out_status_d;
  logic [CountW-1:0]  out_occ_q, out_occ_d;

  logic       in_acc, is_full, is_empty;
  rec_t       new_rec;
  cell_ctrl_t ctrl;

  rec_t                 cell_rec [QueueDepth];
  logic [QueueDepth-1:0] cell_goes;
  logic [QueueDepth-1:0] cell_valid;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign new_rec         = rec_t'(s_axis_tdata_i[RecW-1:0]);
  assign is_full         = (count_q == CountW'(QueueDepth));
  assign is_empty        = (count_q == '0);

  assign ctrl.ins = in_acc && (s_axis_tuser_i == FuncEnq) && !is_full;
  assign ctrl.deq = in_acc && (s_axis_tuser_i == FuncDeq) && !is_empty;

  for (genvar i = 0; i < QueueDepth; i++) begin : g_cell
    rec_t left_rec, right_rec;
    logic left_goes;

    assign cell_valid[i] = (CountW'(i) < count_q);

    if (i == 0) begin : g_head
      assign left_rec  = new_rec;
      assign left_goes = 1'b0;
    end else begin : g_body
      assign left_rec  = cell_rec[i-1];
      assign left_goes = cell_goes[i-1];
    end

    if (i == QueueDepth - 1) begin : g_tail
      assign right_rec = new_rec;
    end else begin : g_inner
      assign right_rec = cell_rec[i+1];
    end

    tkpq_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .valid_i    (cell_valid[i]),
      .new_rec_i  (new_rec),
      .left_rec_i (left_rec),
      .left_goes_i(left_goes),
      .right_rec_i(right_rec),
      .rec_o      (cell_rec[i]),
      .goes_o     (cell_goes[i])
    );
  end

  always_comb begin
    count_d      = count_q;
    out_valid_d  = out_valid_q;
    out_rec_d    = out_rec_q;
    out_status_d = out_status_q;
    out_occ_d    = out_occ_q;
    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (in_acc) begin
      out_valid_d = 1'b1;
      out_rec_d   = '0;
      unique case (s_axis_tuser_i)
        FuncEnq: begin
          if (is_full) begin
            out_status_d = StFull;
          end else begin
            count_d      = count_q + CountW'(1);
            out_status_d = StDone;
          end
        end
        FuncDeq: begin
          if (is_empty) begin
            out_status_d = StEmpty;
          end else begin
            count_d      = count_q - CountW'(1);
            out_rec_d    = cell_rec[0];
            out_status_d = StDone;
          end
        end
        default: begin
          out_status_d = StDone;
        end
      endcase
      out_occ_d = count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_rec_q    <= out_rec_d;
    out_status_q <= out_status_d;
    out_occ_q    <= out_occ_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OutDataW'({out_occ_q, out_rec_q});
  assign m_axis_tuser_o  = out_status_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(QueueDepth))
    else $error("record count above queue depth");

  a_enq_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (s_axis_tuser_i == FuncEnq) && !is_full) |=>
      (count_q == $past(count_q) + CountW'(1)))
    else $error("accepted insert did not grow the count");

  a_empty_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_status_q == StEmpty)) |-> (m_axis_tdata_o == '0))
    else $error("empty result carries data");

  a_head_sorted : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q >= CountW'(2)) |-> !rec_beats(cell_rec[1], cell_rec[0]))
    else $error("head cell is not the highest priority");

endmodule

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// Two-key priority queue testbench
// Sends enqueue and dequeue beats with random idling on both streams. It keeps
// its own sorted copy of the queue to work out each result beat, and checks
// every result field against the oldest expected beat.
// ----------------------------------------------------------------------------
module testbench;
  import tkpq_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned PadW        = OutDataW - RecW - CountW;

  typedef struct packed {
    logic [CountW-1:0]  occupancy;
    logic [StatusW-1:0] status;
    rec_t               rec;
  } q_result_t;

  logic                  clk      = 1'b0;
  logic                  rst_n    = 1'b0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [InDataW-1:0]    s_tdata  = '0;
  logic                  s_tuser  = FuncEnq;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OutDataW-1:0]   m_tdata;
  logic [StatusW-1:0]    m_tuser;

  rec_t        held_recs[$];
  q_result_t   pending_results[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned tx_idle_pct    = 0;
  int unsigned rx_idle_pct    = 0;

  two_key_priority_queue u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  always #5 clk = ~clk;

  // True when record a leaves strictly ahead of record b.
  function automatic logic departs_first(rec_t a, rec_t b);
    if (a.tkey != b.tkey) begin
      return a.tkey < b.tkey;
    end
    return a.counter > b.counter;
  endfunction

  function automatic q_result_t predict_queue_op(logic func, rec_t r);
    q_result_t   res;
    int unsigned pos;
    res = '0;
    if (func == FuncEnq) begin
      if (held_recs.size() >= QueueDepth) begin
        res.status = StFull;
      end else begin
        // A new record goes behind every record it does not strictly beat.
        pos = 0;
        while (pos < held_recs.size() && !departs_first(r, held_recs[pos])) begin
          pos++;
        end
        held_recs.insert(pos, r);
        res.status = StDone;
      end
    end else if (held_recs.size() == 0) begin
      res.status = StEmpty;
    end else begin
      res.rec    = held_recs.pop_front();
      res.status = StDone;
    end
    res.occupancy = CountW'(held_recs.size());
    return res;
  endfunction

  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
      mismatch_count++;
    end
  endfunction

  // Keys are drawn mostly from narrow bands so that ties are common.
  function automatic rec_t random_rec();
    rec_t r;
    r.id = 16'($urandom());
    case ($urandom_range(0, 3))
      0, 1:    r.tkey = $urandom_range(0, 7);
      2:       r.tkey = 32'hFFFF_FFF8 + $urandom_range(0, 7);
      default: r.tkey = $urandom();
    endcase
    case ($urandom_range(0, 2))
      0:       r.counter = 8'($urandom_range(0, 3));
      1:       r.counter = 8'(8'hFC + $urandom_range(0, 3));
      default: r.counter = 8'($urandom());
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // Result beats are checked before the input beat of the same edge is
  // predicted; the block never answers in the cycle it accepts.
  always @(posedge clk) begin
    q_result_t exp_r;
    if (rst_n) begin
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result beat, expected none actual %h/%h",
                   $time, m_tdata, m_tuser);
          mismatch_count++;
        end else begin
          exp_r = pending_results.pop_front();
          check_field("out_id", 64'(exp_r.rec.id), 64'(m_tdata[IdW-1:0]));
          check_field("out_time", 64'(exp_r.rec.tkey), 64'(m_tdata[IdW +: TimeW]));
          check_field("out_counter", 64'(exp_r.rec.counter),
                      64'(m_tdata[IdW+TimeW +: CntrW]));
          check_field("occupancy", 64'(exp_r.occupancy), 64'(m_tdata[RecW +: CountW]));
          check_field("pad", '0, 64'(m_tdata[OutDataW-1 -: PadW]));
          check_field("status", 64'(exp_r.status), 64'(m_tuser));
        end
      end
      if (s_tvalid && s_tready) begin
        pending_results.push_back(predict_queue_op(s_tuser, rec_t'(s_tdata[RecW-1:0])));
      end
    end
  end

  task automatic send_beat(logic func, rec_t r);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= r;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic enqueue(logic [IdW-1:0] id, logic [TimeW-1:0] tkey,
                         logic [CntrW-1:0] counter);
    rec_t r;
    r.id      = id;
    r.tkey    = tkey;
    r.counter = counter;
    send_beat(FuncEnq, r);
  endtask

  // The record fields of a dequeue carry noise; the block must ignore them.
  task automatic dequeue();
    send_beat(FuncDeq, random_rec());
  endtask

  task automatic test_empty_dequeue();
    send_beat(FuncDeq, '1);
    send_beat(FuncDeq, '0);
  endtask

  task automatic test_field_extremes();
    enqueue(16'hFFFF, 32'hFFFF_FFFF, 8'hFF);
    enqueue(16'h0000, 32'h0000_0000, 8'h00);
    enqueue(16'h0000, 32'hFFFF_FFFF, 8'h00);
    enqueue(16'hFFFF, 32'h0000_0000, 8'hFF);
    repeat (4) dequeue();
  endtask

  // Larger counter wins at equal time; full ties leave in arrival order.
  task automatic test_tie_breaks();
    enqueue(16'h0001, 32'd5, 8'd1);
    enqueue(16'h0002, 32'd5, 8'd9);
    enqueue(16'h0003, 32'd5, 8'd9);
    enqueue(16'h0004, 32'd5, 8'd9);
    enqueue(16'h0005, 32'd4, 8'd0);
    repeat (6) dequeue();
  endtask

  // Runs past full so that enqueues are refused, then past empty.
  task automatic test_fill_and_overflow();
    repeat (QueueDepth + 3) send_beat(FuncEnq, random_rec());
    repeat (QueueDepth + 3) dequeue();
  endtask

  // The enqueue share changes every few dozen beats so that the fill level
  // wanders over the whole range.
  task automatic test_random_mix(int unsigned beats);
    int unsigned enq_pct;
    enq_pct = 50;
    for (int unsigned i = 0; i < beats; i++) begin
      if (i % 30 == 0) begin
        case ($urandom_range(0, 2))
          0:       enq_pct = 25;
          1:       enq_pct = 50;
          default: enq_pct = 80;
        endcase
      end
      if ($urandom_range(0, 99) < enq_pct) begin
        send_beat(FuncEnq, random_rec());
      end else begin
        dequeue();
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    tx_idle_pct = 32;
    rx_idle_pct = 72;
    test_empty_dequeue();
    test_field_extremes();
    test_tie_breaks();
    for (int round = 0; round < 3; round++) begin
      case (round)
        0: begin
          tx_idle_pct = 32;
          rx_idle_pct = 72;
        end
        1: begin
          tx_idle_pct = 72;
          rx_idle_pct = 32;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      test_fill_and_overflow();
      test_random_mix(150);
    end
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
